@@ rtl/core/dense_rank_keys_assert.svh @@
// assertion macros shared by the dense rank checker
`ifndef DENSE_RANK_KEYS_ASSERT_SVH
`define DENSE_RANK_KEYS_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define DRK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define DRK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/drk_pkg.sv @@
// shared types and constants of the dense rank block
package drk_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int KEY_W     = 16;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int RANK_W    = 6;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_value;
        logic                    set_end;
    } t_item;

    typedef struct packed {
        logic [RANK_W-1:0] rank_level;
        logic              run_end;
        logic              overflow;
    } t_result;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_value;
        logic                    store;
        logic                    last;
        logic                    ovf;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/core/drk_cmd_fifo.sv @@
// small request queue between the front and the back
module drk_cmd_fifo import drk_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/drk_front.sv @@
// input side: counts keys per set, drops keys past capacity, builds requests
module drk_front import drk_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  t_q_stat i_q_stat,
    output logic    o_full,
    output logic    o_q_push,
    output t_cmd    o_cmd
);

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             accept;
    logic             store;

    assign o_full          = i_q_stat.full;
    assign accept          = i_push && !i_q_stat.full;
    assign store           = (r_count < CNT_W'(MAX_ITEMS));
    assign o_cmd.key_value = i_item.key_value;
    assign o_cmd.store     = store;
    assign o_cmd.last      = i_item.set_end;
    assign o_cmd.ovf       = r_ovf || !store;
    assign o_q_push        = accept && (store || i_item.set_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            if (i_item.set_end) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (store) begin
                r_count <= r_count + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/drk_back.sv @@
// back side: key store, first-occurrence pass, rank pass and result register
module drk_back import drk_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    input  t_cmd    i_cmd,
    output logic    o_q_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic PASS_FIRST = 1'b0;
    localparam logic PASS_RANK  = 1'b1;

    logic [2:0]              r_state;
    logic                    r_pass;
    logic [CNT_W-1:0]        r_wr_cnt;
    logic [IDX_W-1:0]        r_last_idx;
    logic                    r_ovf;
    logic [IDX_W-1:0]        r_o;
    logic [IDX_W-1:0]        r_s;
    logic                    r_p_valid;
    logic [IDX_W-1:0]        r_p_idx;
    logic                    r_match;
    logic [RANK_W-1:0]       r_rank;
    logic                    r_out_valid;
    t_result                 r_out;

    logic signed [KEY_W-1:0] r_key_mem [MAX_ITEMS];
    logic                    r_flag_mem [MAX_ITEMS];
    logic signed [KEY_W-1:0] r_rd_a;
    logic signed [KEY_W-1:0] r_rd_b;
    logic                    r_rd_f;

    logic                    take_cmd;
    logic                    key_we;
    logic                    flag_we;
    logic                    emit_ok;
    logic                    emit;
    logic                    step_done;

    assign take_cmd  = (r_state == S_LOAD) && !i_q_stat.empty;
    assign key_we    = take_cmd && i_cmd.store;
    assign flag_we   = (r_state == S_FINISH) && (r_pass == PASS_FIRST);
    assign emit_ok   = !r_out_valid || i_pop;
    assign emit      = (r_state == S_FINISH) && (r_pass == PASS_RANK) && emit_ok;
    assign step_done = (r_state == S_FINISH) && ((r_pass == PASS_FIRST) || emit_ok);
    assign o_q_pop   = take_cmd;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[r_wr_cnt[IDX_W-1:0]] <= i_cmd.key_value;
        end
        r_rd_a <= r_key_mem[r_o];
        r_rd_b <= r_key_mem[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            r_flag_mem[r_o] <= !r_match;
        end
        r_rd_f <= r_flag_mem[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_pass      <= PASS_FIRST;
            r_wr_cnt    <= '0;
            r_last_idx  <= '0;
            r_ovf       <= 1'b0;
            r_o         <= '0;
            r_s         <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p_valid <= (r_state == S_SCAN);
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (r_p_valid) begin
                if (r_pass == PASS_FIRST) begin
                    if ((r_p_idx < r_o) && (r_rd_b == r_rd_a)) begin
                        r_match <= 1'b1;
                    end
                end else if (r_rd_f && (r_rd_b < r_rd_a)) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
            case (r_state)
                S_LOAD: begin
                    if (take_cmd) begin
                        if (i_cmd.store) begin
                            r_wr_cnt <= r_wr_cnt + 1'b1;
                        end
                        if (i_cmd.last) begin
                            r_last_idx <= IDX_W'(r_wr_cnt + CNT_W'(i_cmd.store) - CNT_W'(1));
                            r_ovf      <= i_cmd.ovf;
                            r_pass     <= PASS_FIRST;
                            r_o        <= '0;
                            r_state    <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_s     <= '0;
                    r_match <= 1'b0;
                    r_rank  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_p_idx   <= r_s;
                    r_s       <= r_s + 1'b1;
                    if (r_s == r_last_idx) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (emit) begin
                        r_out.rank_level <= r_rank;
                        r_out.run_end    <= (r_o == r_last_idx);
                        r_out.overflow   <= r_ovf;
                    end
                    if (step_done) begin
                        if (r_o == r_last_idx) begin
                            if (r_pass == PASS_FIRST) begin
                                r_pass  <= PASS_RANK;
                                r_o     <= '0;
                                r_state <= S_START;
                            end else begin
                                r_wr_cnt <= '0;
                                r_state  <= S_LOAD;
                            end
                        end else begin
                            r_o     <= r_o + 1'b1;
                            r_state <= S_START;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/dense_rank_keys.sv @@
// top level of the dense rank block
// keys load one per cycle while the request queue has room (queue of four requests)
// after the marked key a set of n keys is ranked in two passes:
// each of two passes scans the key store once per key
// rank pass gives one result per key; a result not yet popped stalls it
// i_rst_n is synchronous: queue, counters, sequencer and result valid clear, store is not cleared
module dense_rank_keys import drk_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    t_cmd    front_cmd;
    t_cmd    q_cmd;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    drk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_full   (full),
        .o_q_push (q_push),
        .o_cmd    (front_cmd)
    );

    drk_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    drk_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_cmd    (q_cmd),
        .o_q_pop  (q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

endmodule

@@ rtl/core/drk_checker.sv @@
// port-level checker for the dense rank block and its bind
`include "dense_rank_keys_assert.svh"

module drk_checker import drk_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    push,
    input logic    full,
    input t_item   i_item,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    logic [3:0] r_sets_open;
    logic       r_in_set;
    logic       r_set_ovf;
    logic       set_in;
    logic       set_out;
    logic       res_pop;

    assign res_pop = pop && !empty;
    assign set_in  = push && !full && i_item.set_end;
    assign set_out = res_pop && o_result.run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sets_open <= '0;
            r_in_set    <= 1'b0;
            r_set_ovf   <= 1'b0;
        end else begin
            if (set_in && !set_out) begin
                r_sets_open <= r_sets_open + 1'b1;
            end else if (set_out && !set_in) begin
                r_sets_open <= r_sets_open - 1'b1;
            end
            if (res_pop) begin
                r_in_set  <= !o_result.run_end;
                r_set_ovf <= o_result.overflow;
            end
        end
    end

    `DRK_ASSERT_NXT(a_result_held, !empty && !pop, !empty && $stable(o_result), "result changed while waiting")
    `DRK_ASSERT_IMP(a_result_has_set, !empty, r_sets_open != 4'd0, "result without a closed set")
    `DRK_ASSERT_IMP(a_ovf_constant, res_pop && r_in_set, o_result.overflow == r_set_ovf, "overflow flag changed within a set")

endmodule

bind dense_rank_keys drk_checker u_drk_checker (.*);
